[hdl/bpxh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpxh_pkg
// Shared types and constants for the position hash block: item and result
// payloads, key table geometry and key width.
// ----------------------------------------------------------------------------
package bpxh_pkg;

  localparam int KEY_WIDTH   = 64;
  localparam int TABLE_DEPTH = 775;
  localparam int IDX_W       = 10;
  localparam int WORD_W      = 64;

  // Rights entries sit above the 768 square/piece entries.
  localparam logic [IDX_W-1:0] RIGHTS_BASE = IDX_W'(768);

  // Keep the low KEY_WIDTH bits of a key.
  localparam logic [WORD_W-1:0] KEY_MASK = {WORD_W{1'b1}} >> (WORD_W - KEY_WIDTH);

  typedef enum logic {
    CMD_HASH = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_t;

  typedef struct packed {
    logic              command;
    logic [IDX_W-1:0]  table_index;
    logic [WORD_W-1:0] table_word;
    logic [63:0]       black_pieces;
    logic [63:0]       white_pieces;
    logic [63:0]       king_squares;
    logic [63:0]       queen_squares;
    logic [63:0]       bishop_squares;
    logic [63:0]       knight_squares;
    logic [63:0]       rook_squares;
    logic [63:0]       pawn_squares;
    logic [6:0]        side_flags;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] position_key;
    logic              was_load;
  } result_t;

endpackage

[hdl/bpxh_key_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpxh_key_store
// Key table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bpxh_key_store (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [bpxh_pkg::IDX_W-1:0]  wr_addr,
  input  logic [bpxh_pkg::WORD_W-1:0] wr_data,
  input  logic [bpxh_pkg::IDX_W-1:0]  rd_addr,
  output logic [bpxh_pkg::WORD_W-1:0] rd_data
);
  import bpxh_pkg::*;

  logic [WORD_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/board_position_xor_hash.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// board_position_xor_hash
// Chess position XOR hash over a loadable table of 775 key words.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+----------------------------
//  item     | in  | item_valid / item_ready      | bpxh_pkg::item_t
//  result   | out | result_valid / result_ready  | bpxh_pkg::result_t
//
//  A load transfer writes the table on the accepting edge; its acknowledge is
//  offered from the post step. A hash transfer walks 71 table reads (seven
//  rights entries, then 64 squares), one per cycle through the single read
//  port of the key table, then folds the last read in a drain step and posts
//  the result from the post step.
//  item_ready is high only while the sequencer is idle.
//  A stalled result holds the sequencer in its post step; nothing is dropped.
//  rst (synchronous) clears the sequencer and result_valid; the table itself
//  keeps no reset and holds garbage until software loads it.
// ----------------------------------------------------------------------------
module board_position_xor_hash (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  bpxh_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_ready,
  output bpxh_pkg::result_t   result
);
  import bpxh_pkg::*;

  localparam int               STEP_W    = 7;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(70);
  localparam logic [STEP_W-1:0] SQ_FIRST  = STEP_W'(7);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_POST
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic [WORD_W-1:0] acc;
  logic              was_load;
  logic              hit_q;

  // Working copies of the position; boards shift right one square per square step.
  logic [63:0] black_sh, white_sh;
  logic [5:0][63:0] type_sh;   // king, queen, bishop, knight, rook, pawn
  logic [6:0]  flags;

  logic              hit;
  logic [IDX_W-1:0]  rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;
  logic              slot_free;

  // Table write straight off the accepting edge; out-of-range loads write nothing.
  assign item_ready = (state == S_IDLE);
  assign wr_en      = item_valid && item_ready && (item.command == CMD_LOAD)
                      && (item.table_index < IDX_W'(TABLE_DEPTH));
  assign slot_free  = !result_valid || result_ready;

  bpxh_key_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (item.table_index),
    .wr_data (item.table_word),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Select the table entry for this step and whether it counts.
  logic [5:0]       sq;
  logic [3:0]       piece;
  logic             colored;
  logic             typed;
  logic [IDX_W-1:0] sq_base;

  always_comb begin
    sq      = 6'(step - SQ_FIRST);
    sq_base = {1'b0, sq, 3'b000} + {2'b00, sq, 2'b00};   // sq * 12
    colored = black_sh[0] || white_sh[0];
    typed   = 1'b1;
    piece   = black_sh[0] ? 4'd6 : 4'd0;
    priority if (type_sh[0][0]) piece = piece + 4'd0;
    else if (type_sh[1][0])     piece = piece + 4'd1;
    else if (type_sh[2][0])     piece = piece + 4'd2;
    else if (type_sh[3][0])     piece = piece + 4'd3;
    else if (type_sh[4][0])     piece = piece + 4'd4;
    else if (type_sh[5][0])     piece = piece + 4'd5;
    else                        typed = 1'b0;

    if (step < SQ_FIRST) begin
      // Rights: steps 0/1 are the side to move, 2..6 map onto flag bits 2..6.
      rd_addr = RIGHTS_BASE + IDX_W'(step);
      if (step < STEP_W'(2)) begin
        hit = (flags[1:0] == step[1:0]);
      end else begin
        hit = flags[step[2:0]];
      end
    end else begin
      rd_addr = sq_base + IDX_W'(piece);
      hit     = colored && typed;
    end
    if (state != S_WALK) begin
      hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      hit_q        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      hit_q <= hit;
      // A post in the same cycle refills the output register instead.
      if (result_valid && result_ready && state != S_POST) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            acc      <= '0;
            step     <= '0;
            was_load <= (item.command == CMD_LOAD);
            black_sh <= item.black_pieces;
            white_sh <= item.white_pieces;
            type_sh  <= {item.pawn_squares, item.rook_squares, item.knight_squares,
                         item.bishop_squares, item.queen_squares, item.king_squares};
            flags    <= item.side_flags;
            state    <= (item.command == CMD_LOAD) ? S_POST : S_WALK;
          end
        end
        S_WALK: begin
          // Fold the previous read, issue the next one.
          if (hit_q) acc <= acc ^ rd_data;
          if (step >= SQ_FIRST) begin
            black_sh <= black_sh >> 1;
            white_sh <= white_sh >> 1;
            for (int t = 0; t < 6; t++) type_sh[t] <= type_sh[t] >> 1;
          end
          step <= step + STEP_W'(1);
          if (step == LAST_STEP) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (hit_q) acc <= acc ^ rd_data;
          state <= S_POST;
        end
        S_POST: begin
          // Hold until the output register is free.
          if (slot_free) begin
            result_valid        <= 1'b1;
            result.position_key <= acc & KEY_MASK;
            result.was_load     <= was_load;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_load_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.was_load |-> result.position_key == '0)
    else $error("load acknowledge carries a nonzero key");

  a_hash_start: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item.command == CMD_HASH) |=>
      state == S_WALK && step == '0)
    else $error("hash transfer did not start the walk");

  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK && step == LAST_STEP |=> state == S_DRAIN)
    else $error("walk did not end after the last square");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> step <= LAST_STEP)
    else $error("walk step out of range");

  a_no_hit_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_POST |-> !hit_q)
    else $error("table read still pending at post");

endmodule
